// ===== rtl/phe_pkg.sv =====
package phe_pkg;

  localparam int BIN_COUNT  = 65536;
  localparam int COUNT_BITS = 32;
  localparam int ADDR_W     = $clog2(BIN_COUNT);

  typedef logic [ADDR_W-1:0]     addr_t;
  typedef logic [COUNT_BITS-1:0] cnt_t;

  // pixel modes
  localparam logic [1:0] MODE_U8   = 2'd0;
  localparam logic [1:0] MODE_U16  = 2'd1;
  localparam logic [1:0] MODE_HALF = 2'd2;

  // item functions
  localparam logic [1:0] FUNC_COUNT = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  typedef enum logic {
    ST_RUN,
    ST_CLEAR
  } state_t;

  // round(65535 * half), half away from zero, saturated to 0..65535
  function automatic logic [15:0] half_to_bin(input logic [15:0] h);
    logic        s;
    logic [4:0]  e;
    logic [9:0]  m;
    logic [10:0] sig;
    logic [4:0]  sh;
    logic [27:0] p;
    logic [27:0] r;
    logic [15:0] res;
    s   = h[15];
    e   = h[14:10];
    m   = h[9:0];
    sig = (e == 5'd0) ? {1'b0, m} : {1'b1, m};
    sh  = (e == 5'd0) ? 5'd24 : 5'd25 - e;
    // sig * 65535 as a shift and subtract
    p   = {1'b0, sig, 16'b0} - 28'(sig);
    r   = (p + (28'd1 << (sh - 5'd1))) >> sh;
    if (e == 5'd31) begin
      res = (m != 10'd0 || s) ? 16'd0 : 16'hFFFF;
    end else if (s) begin
      res = 16'd0;
    end else if (e >= 5'd16) begin
      res = 16'hFFFF;
    end else begin
      res = (r > 28'd65535) ? 16'hFFFF : r[15:0];
    end
    return res;
  endfunction

endpackage

// ===== rtl/pixel_histogram_engine.sv =====
// pixel histogram engine: bin counters held in one single-port-write ram
// throughput: one count or read item per cycle while no clear is in progress, sustained by a
//   read, increment, write-back pipeline with forwarding between back-to-back hits on one bin
// read results: strobed on out_valid, registered through stage 1, stage 2 and the output register
// a clear item holds busy until its sweep has zeroed the ram (one ram word zeroed per cycle)
// reset: pixel_mode goes to 0, then a clearing pass over all BIN_COUNT bins runs with busy high
module pixel_histogram_engine (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_func,
  input  logic [15:0] in_pixel_value,
  input  logic [15:0] in_bin_index,
  output logic        out_valid,
  output logic [31:0] out_bin_count,
  output logic [15:0] out_bin_echo,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_wr_data
);

  // bin store, one word per bin, read data registered
  phe_pkg::cnt_t   mem [phe_pkg::BIN_COUNT];
  phe_pkg::cnt_t   mem_rd_r;

  // configuration
  logic [1:0]      mode_r;

  // stage 1: registered item
  logic            s1_valid_r;
  logic [1:0]      s1_func_r;
  logic [15:0]     s1_pix_r;
  logic [15:0]     s1_bidx_r;

  // stage 2: ram data arrives, increment and write back
  logic            s2_count_r;
  logic            s2_read_r;
  logic            s2_clear_r;
  logic            s2_inrange_r;
  phe_pkg::addr_t  s2_addr_r;
  logic [15:0]     s2_echo_r;

  // forwarding of the word written in the same cycle as the stage 1 read
  logic            fwd_hit_r;
  phe_pkg::cnt_t   fwd_data_r;

  // clearing sweep
  phe_pkg::state_t st_r, st_nxt;
  phe_pkg::addr_t  clr_addr_r, clr_addr_nxt;

  // output register
  logic            out_valid_r;
  logic [31:0]     out_count_r;
  logic [15:0]     out_echo_r;

  // stage 1 decode
  logic            s1_count;
  logic            s1_read;
  logic            s1_clear;
  logic            s1_inrange;
  logic [15:0]     pix_bin;
  phe_pkg::addr_t  cnt_addr;
  phe_pkg::addr_t  s1_addr;

  // stage 2 datapath
  phe_pkg::cnt_t   cur_count;
  phe_pkg::cnt_t   inc_count;

  // ram write port
  logic            wr_en;
  phe_pkg::addr_t  wr_addr;
  phe_pkg::cnt_t   wr_data;

  logic            accept;

  // busy while sweeping, or while a clear is still on its way to the sweep
  assign busy = (st_r == phe_pkg::ST_CLEAR)
             || (s1_valid_r && s1_func_r == phe_pkg::FUNC_CLEAR)
             || s2_clear_r;
  assign accept = start && !busy;

  // pixel to bin, per mode; unused mode drops the count
  always_comb begin
    pix_bin  = 16'd0;
    s1_count = 1'b0;
    unique case (mode_r)
      phe_pkg::MODE_U8: begin
        pix_bin  = {8'd0, s1_pix_r[7:0]};
        s1_count = 1'b1;
      end
      phe_pkg::MODE_U16: begin
        pix_bin  = s1_pix_r;
        s1_count = 1'b1;
      end
      phe_pkg::MODE_HALF: begin
        pix_bin  = phe_pkg::half_to_bin(s1_pix_r);
        s1_count = 1'b1;
      end
      default: begin
        pix_bin  = 16'd0;
        s1_count = 1'b0;
      end
    endcase
    s1_count = s1_count && s1_valid_r && (s1_func_r == phe_pkg::FUNC_COUNT);
  end

  always_comb begin
    s1_read    = s1_valid_r && (s1_func_r == phe_pkg::FUNC_READ);
    s1_clear   = s1_valid_r && (s1_func_r == phe_pkg::FUNC_CLEAR);
    s1_inrange = {1'b0, s1_bidx_r} < 17'(phe_pkg::BIN_COUNT);
    // indices past the last bin count into the last bin
    if ({1'b0, pix_bin} >= 17'(phe_pkg::BIN_COUNT)) begin
      cnt_addr = phe_pkg::addr_t'(phe_pkg::BIN_COUNT - 1);
    end else begin
      cnt_addr = phe_pkg::addr_t'(pix_bin);
    end
    s1_addr = s1_count ? cnt_addr : phe_pkg::addr_t'(s1_bidx_r);
  end

  // stage 2: current count with forwarding, increment
  assign cur_count = fwd_hit_r ? fwd_data_r : mem_rd_r;
  assign inc_count = cur_count + phe_pkg::cnt_t'(1);

  // sweep control and ram write port
  always_comb begin
    st_nxt       = st_r;
    clr_addr_nxt = clr_addr_r;
    wr_en        = 1'b0;
    wr_addr      = s2_addr_r;
    wr_data      = inc_count;
    unique case (st_r)
      phe_pkg::ST_RUN: begin
        if (s2_count_r) begin
          wr_en = 1'b1;
        end
        if (s2_clear_r) begin
          st_nxt       = phe_pkg::ST_CLEAR;
          clr_addr_nxt = '0;
        end
      end
      phe_pkg::ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_addr_r;
        wr_data = '0;
        if (clr_addr_r == phe_pkg::addr_t'(phe_pkg::BIN_COUNT - 1)) begin
          st_nxt = phe_pkg::ST_RUN;
        end else begin
          clr_addr_nxt = clr_addr_r + phe_pkg::addr_t'(1);
        end
      end
      default: begin
        st_nxt = phe_pkg::ST_CLEAR;
      end
    endcase
  end

  // bin ram
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    mem_rd_r <= mem[s1_addr];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= phe_pkg::MODE_U8;
      st_r        <= phe_pkg::ST_CLEAR;
      clr_addr_r  <= '0;
      s1_valid_r  <= 1'b0;
      s2_count_r  <= 1'b0;
      s2_read_r   <= 1'b0;
      s2_clear_r  <= 1'b0;
      fwd_hit_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        mode_r <= cfg_wr_data;
      end
      st_r        <= st_nxt;
      clr_addr_r  <= clr_addr_nxt;
      s1_valid_r  <= accept;
      s2_count_r  <= s1_count;
      s2_read_r   <= s1_read;
      s2_clear_r  <= s1_clear;
      // stage 1 reads the bin stage 2 writes at this edge, for a count or a read
      fwd_hit_r   <= s2_count_r && (st_r == phe_pkg::ST_RUN) && (s1_count || s1_read)
                  && (s2_addr_r == s1_addr);
      out_valid_r <= s2_read_r;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_func_r <= in_func;
      s1_pix_r  <= in_pixel_value;
      s1_bidx_r <= in_bin_index;
    end
    s2_addr_r    <= s1_addr;
    s2_echo_r    <= s1_bidx_r;
    s2_inrange_r <= s1_inrange;
    fwd_data_r   <= inc_count;
    out_count_r  <= s2_inrange_r ? 32'(cur_count) : 32'd0;
    out_echo_r   <= s2_echo_r;
  end

  assign out_valid     = out_valid_r;
  assign out_bin_count = out_count_r;
  assign out_bin_echo  = out_echo_r;

endmodule

// ===== dv/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // codes the package leaves unnamed
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic [1:0] FUNC_NOP    = 2'd3;

  // a clear or the reset pass sweeps all BIN_COUNT bins; the limit leaves ample room for them
  localparam int CYCLE_LIMIT = 3000000;
  // settle time after the last reading, before touching the mode
  localparam int SETTLE_CYCLES = 8;

  typedef struct {
    logic [31:0] count;
    logic [15:0] echo;
  } bin_reading_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_func = 2'd0;
  logic [15:0] in_pixel_value = 16'd0;
  logic [15:0] in_bin_index = 16'd0;
  logic        out_valid;
  logic [31:0] out_bin_count;
  logic [15:0] out_bin_echo;
  logic        cfg_wr_en = 1'b0;
  logic [1:0]  cfg_wr_data = 2'd0;

  // histogram mirror: bins absent from the array hold zero
  logic [31:0]  hist_counts [int];
  logic [1:0]   active_mode = phe_pkg::MODE_U8;
  logic [15:0]  last_bin = 16'd0;
  bin_reading_t pending_reads [$];
  bin_reading_t oldest;

  int idle_pct = 0;
  int fail_count = 0;
  int cycle_count = 0;

  pixel_histogram_engine dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_func        (in_func),
    .in_pixel_value (in_pixel_value),
    .in_bin_index   (in_bin_index),
    .out_valid      (out_valid),
    .out_bin_count  (out_bin_count),
    .out_bin_echo   (out_bin_echo),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // half float to bin: round(65535 * f) half away from zero, in integers
  function automatic int half_bin(logic [15:0] h);
    logic            sgn;
    logic [4:0]      ex;
    logic [9:0]      man;
    longint unsigned sig;
    longint unsigned prod;
    longint unsigned rnd;
    int              shift;
    sgn = h[15];
    ex  = h[14:10];
    man = h[9:0];
    // nan and -inf go low, +inf saturates high
    if (ex == 5'd31) return (man != 10'd0 || sgn) ? 0 : 65535;
    // every negative value, -0 too
    if (sgn) return 0;
    // 2.0 and above
    if (ex >= 5'd16) return 65535;
    if (ex == 5'd0) begin
      sig   = longint'(man);
      shift = 24;
    end else begin
      sig   = 1024 + longint'(man);
      shift = 25 - int'(ex);
    end
    prod = sig * 65535;
    rnd  = (prod + (64'd1 << (shift - 1))) >> shift;
    return (rnd > 65535) ? 65535 : int'(rnd);
  endfunction

  // bin a pixel lands in under a mode, -1 when the mode drops counts
  function automatic int pixel_bin(logic [1:0] mode, logic [15:0] pix);
    case (mode)
      phe_pkg::MODE_U8:   return int'(pix[7:0]);
      phe_pkg::MODE_U16:  return int'(pix);
      phe_pkg::MODE_HALF: return half_bin(pix);
      default:            return -1;
    endcase
  endfunction

  // update the mirror for an accepted item, queue the reading a read returns
  function automatic void record_item(logic [1:0] func, logic [15:0] pix,
                                      logic [15:0] idx);
    int           b;
    bin_reading_t r;
    case (func)
      phe_pkg::FUNC_COUNT: begin
        b = pixel_bin(active_mode, pix);
        if (b >= 0) begin
          if (b >= phe_pkg::BIN_COUNT) b = phe_pkg::BIN_COUNT - 1;
          // 32-bit add wraps the count
          hist_counts[b] = hist_counts.exists(b) ? hist_counts[b] + 32'd1 : 32'd1;
          last_bin = 16'(b);
        end
      end
      phe_pkg::FUNC_READ: begin
        r.count = hist_counts.exists(int'(idx)) ? hist_counts[int'(idx)] : 32'd0;
        r.echo  = idx;
        pending_reads.push_back(r);
      end
      phe_pkg::FUNC_CLEAR: hist_counts.delete();
      default: ;
    endcase
  endfunction

  // result checker: a reading is taken at the edge closing its strobe cycle
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) begin
      if (pending_reads.size() == 0) begin
        $error("unexpected reading: bin_count %0d bin_echo %0d", out_bin_count,
               out_bin_echo);
        fail_count = fail_count + 1;
      end else begin
        oldest = pending_reads.pop_front();
        if (out_bin_count !== oldest.count) begin
          $error("bin_count: expected %0d, got %0d", oldest.count, out_bin_count);
          fail_count = fail_count + 1;
        end
        if (out_bin_echo !== oldest.echo) begin
          $error("bin_echo: expected %0d, got %0d", oldest.echo, out_bin_echo);
          fail_count = fail_count + 1;
        end
      end
    end
  end

  // one item: optional idle gap, then hold start until the engine takes it
  task automatic send_item(input logic [1:0] func, input logic [15:0] pix,
                           input logic [15:0] idx);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start          <= 1'b1;
    in_func        <= func;
    in_pixel_value <= pix;
    in_bin_index   <= idx;
    @(posedge clk);
    while (busy) @(posedge clk);
    record_item(func, pix, idx);
  endtask

  // stop sending and wait for every reading and any clear to finish
  task automatic finish_pending();
    start <= 1'b0;
    while (pending_reads.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // mode changes only on an idle engine
  task automatic set_mode(input logic [1:0] mode);
    finish_pending();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= mode;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    active_mode = mode;
  endtask

  task automatic apply_reset();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    // the engine wipes its store after reset, busy stays high meanwhile
    repeat (4) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // store reads zero straight out of reset
  task automatic test_reset_state();
    send_item(phe_pkg::FUNC_READ, 16'h5A5A, 16'hFFFF);
  endtask

  // low byte only, back-to-back hits on one bin
  task automatic test_u8_bins();
    set_mode(phe_pkg::MODE_U8);
    send_item(phe_pkg::FUNC_COUNT, 16'h00FF, 16'h0000);
    send_item(phe_pkg::FUNC_COUNT, 16'hAB00, 16'hFFFF);
    send_item(phe_pkg::FUNC_COUNT, 16'hAB00, 16'h1234);
    send_item(phe_pkg::FUNC_READ, 16'h0000, 16'h00FF);
    send_item(phe_pkg::FUNC_READ, 16'hFFFF, 16'h0000);
  endtask

  // top bin, read right behind its count
  task automatic test_u16_bins();
    set_mode(phe_pkg::MODE_U16);
    send_item(phe_pkg::FUNC_COUNT, 16'hFFFF, 16'h0000);
    send_item(phe_pkg::FUNC_READ, 16'h0000, 16'hFFFF);
  endtask

  // half float corners: signs, nan, infinities, above one, rounding ties
  task automatic test_half_float_bins();
    set_mode(phe_pkg::MODE_HALF);
    send_item(phe_pkg::FUNC_COUNT, 16'h8000, 16'h0000);  // negative zero
    send_item(phe_pkg::FUNC_COUNT, 16'h7E00, 16'h0000);  // nan
    send_item(phe_pkg::FUNC_COUNT, 16'hFC00, 16'h0000);  // negative infinity
    send_item(phe_pkg::FUNC_COUNT, 16'h0001, 16'h0000);  // smallest subnormal
    send_item(phe_pkg::FUNC_COUNT, 16'h3C01, 16'h0000);  // just above one
    send_item(phe_pkg::FUNC_COUNT, 16'h7C00, 16'h0000);  // positive infinity
    send_item(phe_pkg::FUNC_COUNT, 16'h3800, 16'h0000);  // one half, rounds up
    send_item(phe_pkg::FUNC_COUNT, 16'h3BFF, 16'h0000);  // just below one
    send_item(phe_pkg::FUNC_READ, 16'h0000, 16'h0000);
    send_item(phe_pkg::FUNC_READ, 16'h0000, 16'hFFFF);
    send_item(phe_pkg::FUNC_READ, 16'h0000, 16'h8000);
    send_item(phe_pkg::FUNC_READ, 16'h0000, 16'hFFDF);
  endtask

  // unused mode drops counts, unused func does nothing, clear wipes all
  task automatic test_unused_codes();
    set_mode(MODE_UNUSED);
    send_item(phe_pkg::FUNC_COUNT, 16'h0000, 16'h0000);
    send_item(FUNC_NOP, 16'hFFFF, 16'hFFFF);
    send_item(phe_pkg::FUNC_READ, 16'h0000, 16'h0000);
    send_item(phe_pkg::FUNC_CLEAR, 16'h0000, 16'h0000);
    send_item(phe_pkg::FUNC_READ, 16'h0000, 16'h0000);
  endtask

  // mode segments of mixed traffic; counts draw mostly from a small pool of pixels so
  // bins collide, reads target the last counted bin, a pool bin or a random index
  task automatic test_random_traffic(input int idle, input int target, input int clears);
    int          done_items;
    int          seg_len;
    int          pick;
    logic [1:0]  mode;
    logic [1:0]  func;
    logic [15:0] pix;
    logic [15:0] idx;
    logic [15:0] hot [8];
    idle_pct   = idle;
    done_items = 0;
    while (done_items < target) begin
      // mostly real modes, now and then the unused one
      mode = ($urandom_range(7) == 0) ? MODE_UNUSED : 2'($urandom_range(2));
      set_mode(mode);
      seg_len = (mode == MODE_UNUSED) ? 15 : $urandom_range(40, 90);
      for (int i = 0; i < 8; i++) begin
        // half mode pool mostly in zero to two, where bins spread out
        if (mode == phe_pkg::MODE_HALF && $urandom_range(3) != 0)
          hot[i] = {1'b0, 5'($urandom_range(15)), 10'($urandom)};
        else
          hot[i] = 16'($urandom);
      end
      for (int n = 0; n < seg_len && done_items < target; n++) begin
        pick = $urandom_range(99);
        if (pick < 62) begin
          func = phe_pkg::FUNC_COUNT;
        end else if (pick < 96) begin
          func = phe_pkg::FUNC_READ;
        end else if (pick < 99 || clears == 0) begin
          func = FUNC_NOP;
        end else begin
          func = phe_pkg::FUNC_CLEAR;
          clears = clears - 1;
        end
        pix = ($urandom_range(99) < 60) ? hot[$urandom_range(7)] : 16'($urandom);
        case ($urandom_range(3))
          0: idx = last_bin;
          1: idx = (mode == MODE_UNUSED) ? 16'($urandom)
                                         : 16'(pixel_bin(mode, hot[$urandom_range(7)]));
          2: idx = 16'($urandom);
          default: idx = (mode == phe_pkg::MODE_U8) ? 16'($urandom_range(255))
                                                    : 16'($urandom);
        endcase
        // ignored items do not count toward the target
        if (!(func == FUNC_NOP || (func == phe_pkg::FUNC_COUNT && mode == MODE_UNUSED)))
          done_items = done_items + 1;
        send_item(func, pix, idx);
      end
    end
  endtask

  initial begin
    apply_reset();
    test_reset_state();
    test_u8_bins();
    test_u16_bins();
    test_half_float_bins();
    test_unused_codes();
    // sender mostly busy, then mostly idle, then back to back
    test_random_traffic(7, 310, 1);
    test_random_traffic(86, 310, 1);
    test_random_traffic(0, 310, 1);
    finish_pending();
    if (fail_count == 0 && pending_reads.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
